// ----- rtl/core/pvs_pkg.sv -----
`timescale 1ns / 1ps

package pvs_pkg;

	localparam int NUM_FRAMES_DEF = 32;
	localparam int FRAME_W        = 5;
	localparam int TICK_W         = 31;
	localparam int COUNT_W        = 32;
	localparam int POLICY_W       = 3;

	localparam logic [POLICY_W-1:0] POL_FIFO   = 3'd0;
	localparam logic [POLICY_W-1:0] POL_SC     = 3'd1;
	localparam logic [POLICY_W-1:0] POL_ESC    = 3'd2;
	localparam logic [POLICY_W-1:0] POL_LRU    = 3'd3;
	localparam logic [POLICY_W-1:0] POL_LFU    = 3'd4;
	localparam logic [POLICY_W-1:0] POL_RANDOM = 3'd5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hffffffff;

	typedef struct packed {
		logic               used;
		logic               dirty;
		logic [TICK_W-1:0]  stamp;
		logic [COUNT_W-1:0] count;
	} pvs_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_FIN_RD,
		ST_FIN_WR
	} pvs_state_t;

endpackage

// ----- rtl/core/page_victim_selector.sv -----
`timescale 1ns / 1ps
// access item: read in ACC_RD, written back in ACC_WR, then back to idle; no result
// fifo and random victim: result in FIN_WR after the FIN_RD read, held there while res_ready is low
// second chance: SCAN_RD then SCAN_EV for each frame, a read-modify-write that clears the used bit
// enhanced second chance, lru, lfu: at most one pass of SCAN_RD and SCAN_EV over the frame memory
// one item at a time; reset clears all frame state at once via per-frame valid bits, policy 5
module page_victim_selector #(
	parameter int NUM_FRAMES = pvs_pkg::NUM_FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [pvs_pkg::FRAME_W-1:0]   frame,
	input  logic                          is_write,
	input  logic [pvs_pkg::TICK_W-1:0]    tick,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pvs_pkg::FRAME_W-1:0]   victim_frame,
	output logic                          victim_dirty,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pvs_pkg::POLICY_W-1:0]  cfg_data
);
	import pvs_pkg::*;

	localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

	logic [POLICY_W-1:0] policy_q;
	logic                res_valid, res_ready, res_dirty;
	logic [FW-1:0]       res_frame;
	logic [FW+4:0]       res_x;
	logic [FRAME_W-1:0]  frame_q;
	logic                dirty_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_RANDOM;
		end else if (cfg_valid && cfg_ready) begin
			policy_q <= cfg_data;
		end
	end

	pvs_seq #(
		.NUM_FRAMES(NUM_FRAMES),
		.FW        (FW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.frame    (frame),
		.is_write (is_write),
		.tick     (tick),
		.policy   (policy_q),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.res_frame(res_frame),
		.res_dirty(res_dirty)
	);

	// output register
	assign res_ready = !out_valid || out_ready;
	assign res_x     = {5'b0, res_frame};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_ready) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			frame_q <= res_x[FRAME_W-1:0];
			dirty_q <= res_dirty;
		end
	end

	assign victim_frame = frame_q;
	assign victim_dirty = dirty_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer taken while busy");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid || out_ready))
		else $error("result overwrites pending output");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, res_frame} < (FW + 1)'(NUM_FRAMES)))
		else $error("victim out of range");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !in_ready)
		else $error("result while idle");

endmodule

// ----- rtl/core/pvs_frame_mem.sv -----
`timescale 1ns / 1ps

module pvs_frame_mem #(
	parameter int NUM_FRAMES = 32,
	parameter int FW         = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [FW-1:0]       waddr,
	input  pvs_pkg::pvs_entry_t wdata,
	input  logic                re,
	input  logic [FW-1:0]       raddr,
	output pvs_pkg::pvs_entry_t rdata
);
	import pvs_pkg::*;

	pvs_entry_t            mem [NUM_FRAMES];
	pvs_entry_t            rdata_s1;
	logic                  rvld_s1;
	logic [NUM_FRAMES-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_s1 <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_s1 ? rdata_s1 : '0;

endmodule

// ----- rtl/core/pvs_seq.sv -----
`timescale 1ns / 1ps

module pvs_seq #(
	parameter int NUM_FRAMES = 32,
	parameter int FW         = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [pvs_pkg::FRAME_W-1:0]      frame,
	input  logic                             is_write,
	input  logic [pvs_pkg::TICK_W-1:0]       tick,
	input  logic [pvs_pkg::POLICY_W-1:0]     policy,
	input  logic                             res_ready,
	output logic                             res_valid,
	output logic [FW-1:0]                    res_frame,
	output logic                             res_dirty
);
	import pvs_pkg::*;

	localparam logic [FW-1:0] LAST = FW'(NUM_FRAMES - 1);

	pvs_state_t state_q, state_d;

	logic [FW-1:0]       ptr_q, ptr_d;
	logic [FW-1:0]       cnt_q, cnt_d;
	logic [FW-1:0]       victim_q, victim_d;
	logic [FW-1:0]       best_idx_q, best_idx_d;
	logic [COUNT_W-1:0]  best_q, best_d;
	logic [3:1]          seen_q, seen_d;
	logic [FW-1:0]       first_q [3:1];
	logic [FW-1:0]       first_d [3:1];
	logic [POLICY_W-1:0] pol_q;
	logic [FW-1:0]       addr_q;
	logic                wr_q;
	logic [TICK_W-1:0]   tick_q;

	logic                we, re;
	logic [FW-1:0]       waddr, raddr;
	pvs_entry_t          wdata, e;
	logic [FW-1:0]       ptr_nxt, rnd, pick;
	logic [1:0]          cls;
	logic [COUNT_W-1:0]  val;
	logic [FW+4:0]       frame_x;
	logic                frame_ok;

	pvs_frame_mem #(
		.NUM_FRAMES(NUM_FRAMES),
		.FW        (FW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (e)
	);

	assign ptr_nxt  = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
	assign frame_x  = {{FW{1'b0}}, frame};
	assign frame_ok = ({1'b0, frame_x} < (FW + 6)'(NUM_FRAMES));
	assign rnd      = tick[FW-1:0] & LAST;
	assign cls      = {e.used, e.dirty};
	assign val      = (pol_q == POL_LRU) ? {1'b0, e.stamp} : e.count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			seen_q  <= '0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			seen_q  <= seen_d;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q      <= cnt_d;
		victim_q   <= victim_d;
		best_idx_q <= best_idx_d;
		best_q     <= best_d;
		first_q    <= first_d;
		if (in_valid && in_ready) begin
			pol_q  <= policy;
			addr_q <= frame_x[FW-1:0];
			wr_q   <= is_write;
			tick_q <= tick;
		end
	end

	always_comb begin
		state_d    = state_q;
		ptr_d      = ptr_q;
		cnt_d      = cnt_q;
		victim_d   = victim_q;
		best_idx_d = best_idx_q;
		best_d     = best_q;
		seen_d     = seen_q;
		first_d    = first_q;
		in_ready   = 1'b0;
		res_valid  = 1'b0;
		res_dirty  = e.dirty;
		we         = 1'b0;
		waddr      = ptr_q;
		wdata      = e;
		re         = 1'b0;
		raddr      = ptr_q;
		pick       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cnt_d    = '0;
				seen_d   = '0;
				if (in_valid) begin
					if (!action) begin
						if (frame_ok) begin
							state_d = ST_ACC_RD;
						end
					end else begin
						unique case (policy)
							POL_FIFO: begin
								victim_d = ptr_q;
								ptr_d    = ptr_nxt;
								state_d  = ST_FIN_RD;
							end
							POL_SC, POL_ESC, POL_LRU, POL_LFU: begin
								state_d = ST_SCAN_RD;
							end
							default: begin
								victim_d = ({1'b0, rnd} < (FW + 1)'(NUM_FRAMES)) ? rnd : '0;
								state_d  = ST_FIN_RD;
							end
						endcase
					end
				end
			end
			ST_ACC_RD: begin
				re      = 1'b1;
				raddr   = addr_q;
				state_d = ST_ACC_WR;
			end
			ST_ACC_WR: begin
				we          = 1'b1;
				waddr       = addr_q;
				wdata.used  = 1'b1;
				wdata.dirty = e.dirty | wr_q;
				wdata.stamp = tick_q;
				wdata.count = (e.count == COUNT_MAX) ? e.count : e.count + 1'b1;
				state_d     = ST_IDLE;
			end
			ST_SCAN_RD: begin
				re      = 1'b1;
				raddr   = (pol_q == POL_LRU || pol_q == POL_LFU) ? cnt_q : ptr_q;
				state_d = ST_SCAN_EV;
			end
			ST_SCAN_EV: begin
				state_d = ST_SCAN_RD;
				cnt_d   = cnt_q + 1'b1;
				priority if (pol_q == POL_SC) begin
					ptr_d = ptr_nxt;
					if (!e.used) begin
						victim_d = ptr_q;
						state_d  = ST_FIN_RD;
					end else begin
						we         = 1'b1;
						wdata.used = 1'b0;
					end
				end else if (pol_q == POL_ESC) begin
					ptr_d = ptr_nxt;
					if (cls == 2'd0) begin
						victim_d = ptr_q;
						state_d  = ST_FIN_RD;
					end else begin
						if (cls[1]) begin
							we         = 1'b1;
							wdata.used = 1'b0;
						end
						if (!seen_q[cls]) begin
							seen_d[cls]  = 1'b1;
							first_d[cls] = ptr_q;
						end
						if (cnt_q == LAST) begin
							priority if (seen_d[1]) pick = first_d[1];
							else if (seen_d[2])     pick = first_d[2];
							else if (seen_d[3])     pick = first_d[3];
							else                    pick = '0;
							victim_d = pick;
							ptr_d    = (pick == LAST) ? '0 : pick + 1'b1;
							state_d  = ST_FIN_RD;
						end
					end
				end else begin
					if (cnt_q == '0 || val < best_q) begin
						best_d     = val;
						best_idx_d = cnt_q;
					end
					if (cnt_q == LAST) begin
						victim_d = best_idx_d;
						state_d  = ST_FIN_RD;
					end
				end
			end
			ST_FIN_RD: begin
				re      = 1'b1;
				raddr   = victim_q;
				state_d = ST_FIN_WR;
			end
			ST_FIN_WR: begin
				waddr       = victim_q;
				wdata.used  = 1'b0;
				wdata.dirty = 1'b0;
				if (res_ready) begin
					we        = 1'b1;
					res_valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_frame = victim_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

class victim_scoreboard;
	localparam int NF = pvs_pkg::NUM_FRAMES_DEF;

	logic [pvs_pkg::POLICY_W-1:0] pol;
	bit use_b[NF];
	bit dirty_b[NF];
	logic [pvs_pkg::TICK_W-1:0] stamp[NF];
	logic [pvs_pkg::COUNT_W-1:0] cnt[NF];
	int ptr;
	logic [pvs_pkg::FRAME_W-1:0] exp_frame_q[$];
	bit exp_dirty_q[$];
	int errors;

	function new();
		pol = pvs_pkg::POL_RANDOM;
		for (int i = 0; i < NF; i++) begin
			use_b[i] = 0;
			dirty_b[i] = 0;
			stamp[i] = '0;
			cnt[i] = '0;
		end
		ptr = 0;
		errors = 0;
	endfunction

	function int take_next();
		int f;
		f = ptr;
		ptr = (f + 1 >= NF) ? 0 : f + 1;
		return f;
	endfunction

	function int pick_sc();
		int f;
		for (int n = 0; n < 2 * NF; n++) begin
			f = take_next();
			if (!use_b[f])
				return f;
			use_b[f] = 0;
		end
		return take_next();
	endfunction

	function int pick_esc();
		bit seen[4];
		int first[4];
		int f;
		int cls;
		for (int c = 0; c < 4; c++) begin
			seen[c] = 0;
			first[c] = 0;
		end
		for (int n = 0; n < NF; n++) begin
			f = take_next();
			cls = 2 * use_b[f] + dirty_b[f];
			if (cls == 0)
				return f;
			if (cls >= 2)
				use_b[f] = 0;
			if (!seen[cls]) begin
				seen[cls] = 1;
				first[cls] = f;
			end
		end
		for (int c = 1; c < 4; c++) begin
			if (seen[c]) begin
				ptr = (first[c] + 1 >= NF) ? 0 : first[c] + 1;
				return first[c];
			end
		end
		return 0;
	endfunction

	function int pick_oldest();
		int best;
		best = 0;
		for (int i = 1; i < NF; i++)
			if (stamp[i] < stamp[best])
				best = i;
		return best;
	endfunction

	function int pick_rarest();
		int best;
		best = 0;
		for (int i = 1; i < NF; i++)
			if (cnt[i] < cnt[best])
				best = i;
		return best;
	endfunction

	function void note_item(bit act, logic [4:0] fr, bit wr, logic [30:0] tk);
		int v;
		if (act == 0) begin
			if (fr < NF) begin
				use_b[fr] = 1;
				if (wr)
					dirty_b[fr] = 1;
				stamp[fr] = tk;
				if (cnt[fr] != pvs_pkg::COUNT_MAX)
					cnt[fr] = cnt[fr] + 1;
			end
			return;
		end
		case (pol)
			pvs_pkg::POL_FIFO: v = take_next();
			pvs_pkg::POL_SC: v = pick_sc();
			pvs_pkg::POL_ESC: v = pick_esc();
			pvs_pkg::POL_LRU: v = pick_oldest();
			pvs_pkg::POL_LFU: v = pick_rarest();
			default: v = tk & (NF - 1);
		endcase
		if (v >= NF)
			v = 0;
		exp_frame_q.push_back(v[4:0]);
		exp_dirty_q.push_back(dirty_b[v]);
		use_b[v] = 0;
		dirty_b[v] = 0;
	endfunction

	function void check_result(logic [4:0] fr, logic dt);
		logic [4:0] ef;
		bit ed;
		if (exp_frame_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected victim transfer: frame %0d dirty %0d", fr, dt);
			return;
		end
		ef = exp_frame_q.pop_front();
		ed = exp_dirty_q.pop_front();
		if (fr !== ef || dt !== ed) begin
			errors++;
			if (errors <= 10)
				$display("victim mismatch: expected frame %0d dirty %0d, got frame %0d dirty %0d",
					ef, ed, fr, dt);
		end
	endfunction
endclass

module tb_top;
	localparam logic [2:0] POL_RSV6 = 3'd6;
	localparam logic [2:0] POL_RSV7 = 3'd7;
	localparam int WD_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic action;
	logic [pvs_pkg::FRAME_W-1:0] frame;
	logic is_write;
	logic [pvs_pkg::TICK_W-1:0] tick;
	logic out_valid;
	logic out_ready;
	logic [pvs_pkg::FRAME_W-1:0] victim_frame;
	logic victim_dirty;
	logic cfg_valid;
	logic cfg_ready;
	logic [pvs_pkg::POLICY_W-1:0] cfg_data;

	victim_scoreboard sb;
	int snd_idle;
	int rcv_idle;
	bit hold_req;
	bit in_high;
	int quiet;

	page_victim_selector u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .frame(frame), .is_write(is_write), .tick(tick),
		.out_valid(out_valid), .out_ready(out_ready),
		.victim_frame(victim_frame), .victim_dirty(victim_dirty),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(victim_frame, victim_dirty);
	end

	always @(posedge clk) begin
		if (hold_req) begin
			out_ready <= 1'b0;
			repeat (300) @(posedge clk);
			hold_req = 0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WD_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_item(bit act, logic [4:0] fr, bit wr, logic [30:0] tk);
		in_valid <= 1'b1;
		action <= act;
		frame <= fr;
		is_write <= wr;
		tick <= tk;
		in_high = 1;
		do @(posedge clk); while (!in_ready);
		sb.note_item(act, fr, wr, tk);
		if ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			in_high = 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		if (in_high) begin
			in_valid <= 1'b0;
			in_high = 0;
		end
		while (sb.exp_frame_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_policy(logic [2:0] p);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= p;
		do @(posedge clk); while (!cfg_ready);
		sb.pol = p;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [30:0] rand_tick();
		case ($urandom_range(0, 3))
			0: return 31'($urandom_range(0, 63));
			1: return 31'h7fffffff;
			default: return 31'($urandom());
		endcase
	endfunction

	task automatic random_items(int n);
		for (int i = 0; i < n; i++)
			send_item($urandom_range(0, 99) < 30, 5'($urandom_range(0, 31)),
				1'($urandom_range(0, 1)), rand_tick());
	endtask

	initial begin
		logic [2:0] pols[8];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = 1'b0;
		frame = '0;
		is_write = 1'b0;
		tick = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		snd_idle = 0;
		rcv_idle = 0;
		hold_req = 0;
		in_high = 0;
		quiet = 0;
		pols = '{pvs_pkg::POL_FIFO, pvs_pkg::POL_SC, pvs_pkg::POL_ESC, pvs_pkg::POL_LRU,
			pvs_pkg::POL_LFU, pvs_pkg::POL_RANDOM, POL_RSV6, POL_RSV7};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset policy is random
		send_item(1, 5'd0, 0, 31'd0);
		send_item(0, 5'd31, 1, 31'h7fffffff);
		send_item(0, 5'd0, 0, 31'd0);
		send_item(1, 5'd0, 0, 31'h7fffffff);
		send_item(1, 5'd0, 0, 31'd0);
		// every stamp at maximum, lru falls back to frame 0
		write_policy(pvs_pkg::POL_LRU);
		for (int i = 0; i < 32; i++)
			send_item(0, i[4:0], i[0], 31'h7fffffff);
		send_item(1, 5'd7, 1, 31'h2aaaaaaa);
		write_policy(pvs_pkg::POL_LFU);
		send_item(1, 5'd0, 0, 31'd5);

		for (int m = 0; m < 3; m++) begin
			snd_idle = (m == 0) ? 27 : (m == 1) ? 78 : 0;
			rcv_idle = (m == 0) ? 78 : (m == 1) ? 27 : 0;
			for (int p = 0; p < 8; p++) begin
				write_policy(pols[p]);
				if (m == 0 && p == 0)
					hold_req = 1;
				random_items(75);
			end
		end

		wait_idle();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
